### design/ocv_pkg.sv
// Package for the open-circuit-voltage to state-of-charge interpolator.
// Holds the fixed voltage/percent point table, widths and shared types.
// No dependencies.
`default_nettype none

package ocv_pkg;

  localparam int ROM_POINTS = 101;
  localparam int ROM_IW     = 7;
  localparam int MV_W       = 16;
  localparam int PCT_W      = 8;
  localparam int OUT_W      = 14;
  localparam int BASE_W     = 15;
  localparam int QUO_W      = 15;
  localparam int NUM_W      = 31;

  typedef logic [ROM_IW-1:0] rom_idx_t;

  // Sideband carried alongside the divider.
  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              use_q;
  } side_t;

  localparam logic [MV_W-1:0] ROM_MV [ROM_POINTS] = '{
    16'd3000, 16'd3150, 16'd3205, 16'd3245, 16'd3275,
    16'd3300, 16'd3324, 16'd3348, 16'd3372, 16'd3396,
    16'd3420, 16'd3434, 16'd3448, 16'd3462, 16'd3476,
    16'd3490, 16'd3502, 16'd3514, 16'd3526, 16'd3538,
    16'd3550, 16'd3558, 16'd3566, 16'd3574, 16'd3582,
    16'd3590, 16'd3598, 16'd3606, 16'd3614, 16'd3622,
    16'd3630, 16'd3636, 16'd3642, 16'd3648, 16'd3654,
    16'd3660, 16'd3666, 16'd3672, 16'd3678, 16'd3684,
    16'd3690, 16'd3696, 16'd3702, 16'd3708, 16'd3714,
    16'd3720, 16'd3726, 16'd3732, 16'd3738, 16'd3744,
    16'd3750, 16'd3756, 16'd3762, 16'd3768, 16'd3774,
    16'd3780, 16'd3786, 16'd3792, 16'd3798, 16'd3804,
    16'd3810, 16'd3816, 16'd3822, 16'd3828, 16'd3834,
    16'd3840, 16'd3848, 16'd3856, 16'd3864, 16'd3872,
    16'd3880, 16'd3888, 16'd3896, 16'd3904, 16'd3912,
    16'd3920, 16'd3926, 16'd3932, 16'd3938, 16'd3944,
    16'd3950, 16'd3958, 16'd3966, 16'd3974, 16'd3982,
    16'd3990, 16'd4002, 16'd4014, 16'd4026, 16'd4038,
    16'd4050, 16'd4064, 16'd4078, 16'd4092, 16'd4106,
    16'd4120, 16'd4136, 16'd4152, 16'd4168, 16'd4184,
    16'd4200
  };

  localparam logic [PCT_W-1:0] ROM_PCT [ROM_POINTS] = '{
    8'd0,  8'd1,  8'd2,  8'd3,  8'd4,  8'd5,  8'd6,  8'd7,  8'd8,  8'd9,
    8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19,
    8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29,
    8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39,
    8'd40, 8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49,
    8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd59,
    8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69,
    8'd70, 8'd71, 8'd72, 8'd73, 8'd74, 8'd75, 8'd76, 8'd77, 8'd78, 8'd79,
    8'd80, 8'd81, 8'd82, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87, 8'd88, 8'd89,
    8'd90, 8'd91, 8'd92, 8'd93, 8'd94, 8'd95, 8'd96, 8'd97, 8'd98, 8'd99,
    8'd100
  };

endpackage

`default_nettype wire

### design/ocv_search.sv
// Pipelined binary search over the point table, one count bit per stage.
// Depends on ocv_pkg.
`default_nettype none

module ocv_search #(
  parameter int NU = 101,
  parameter int LW = 7
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        vld_i,
  input  wire logic [ocv_pkg::MV_W-1:0]    v_i,
  output logic                             vld_o,
  output logic [ocv_pkg::MV_W-1:0]         v_o,
  output logic [LW-1:0]                    cnt_o
);

  logic                     vld_q [LW];
  logic [ocv_pkg::MV_W-1:0] v_q   [LW];
  logic [LW-1:0]            cnt_q [LW];
  logic                     vld_d [LW];
  logic [ocv_pkg::MV_W-1:0] v_d   [LW];
  logic [LW-1:0]            cnt_d [LW];

  // The count is the number of points below the voltage.
  always_comb begin
    logic [LW-1:0]            cnt_in;
    logic [ocv_pkg::MV_W-1:0] v_in;
    logic                     vld_in;
    logic [LW-1:0]            cand;
    logic [LW-1:0]            idx;
    for (int s = 0; s < LW; s++) begin
      if (s == 0) begin
        cnt_in = '0;
        v_in   = v_i;
        vld_in = vld_i;
      end else begin
        cnt_in = cnt_q[s-1];
        v_in   = v_q[s-1];
        vld_in = vld_q[s-1];
      end
      cand = cnt_in | (LW'(1) << (LW - 1 - s));
      idx  = (cand <= LW'(NU)) ? cand - LW'(1) : '0;
      if ((cand <= LW'(NU)) && (ocv_pkg::ROM_MV[ocv_pkg::rom_idx_t'(idx)] < v_in)) begin
        cnt_d[s] = cand;
      end else begin
        cnt_d[s] = cnt_in;
      end
      v_d[s]   = v_in;
      vld_d[s] = vld_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LW; s++) vld_q[s] <= 1'b0;
    end else if (en_i) begin
      for (int s = 0; s < LW; s++) vld_q[s] <= vld_d[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < LW; s++) begin
        v_q[s]   <= v_d[s];
        cnt_q[s] <= cnt_d[s];
      end
    end
  end

  assign vld_o = vld_q[LW-1];
  assign v_o   = v_q[LW-1];
  assign cnt_o = cnt_q[LW-1];

endmodule

`default_nettype wire

### design/ocv_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ocv_pkg.
`default_nettype none

module ocv_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         vld_i,
  input  wire logic [ocv_pkg::NUM_W-1:0]    num_i,
  input  wire logic [ocv_pkg::MV_W-1:0]     den_i,
  input  wire ocv_pkg::side_t               side_i,
  output logic                              vld_o,
  output logic [ocv_pkg::QUO_W-1:0]         quo_o,
  output ocv_pkg::side_t                    side_o
);

  localparam int DS = ocv_pkg::QUO_W;
  localparam int DW = ocv_pkg::MV_W;

  logic                         vld_q  [DS];
  logic [DW-1:0]                rem_q  [DS];
  logic [ocv_pkg::NUM_W-1:0]    num_q  [DS];
  logic [DW-1:0]                den_q  [DS];
  logic [ocv_pkg::QUO_W-1:0]    quo_q  [DS];
  ocv_pkg::side_t               side_q [DS];

  logic                         vld_d  [DS];
  logic [DW-1:0]                rem_d  [DS];
  logic [ocv_pkg::NUM_W-1:0]    num_d  [DS];
  logic [DW-1:0]                den_d  [DS];
  logic [ocv_pkg::QUO_W-1:0]    quo_d  [DS];
  ocv_pkg::side_t               side_d [DS];

  // The quotient fits QUO_W bits, so the upper numerator bits are already
  // below the divisor and seed the remainder directly.
  always_comb begin
    logic [DW-1:0]             rem_in;
    logic [ocv_pkg::NUM_W-1:0] num_in;
    logic [DW-1:0]             den_in;
    logic [ocv_pkg::QUO_W-1:0] quo_in;
    logic [DW:0]               trial;
    logic                      ge;
    for (int k = 0; k < DS; k++) begin
      if (k == 0) begin
        rem_in    = num_i[ocv_pkg::NUM_W-1:ocv_pkg::QUO_W];
        num_in    = num_i;
        den_in    = den_i;
        quo_in    = '0;
        vld_d[k]  = vld_i;
        side_d[k] = side_i;
      end else begin
        rem_in    = rem_q[k-1];
        num_in    = num_q[k-1];
        den_in    = den_q[k-1];
        quo_in    = quo_q[k-1];
        vld_d[k]  = vld_q[k-1];
        side_d[k] = side_q[k-1];
      end
      trial    = {rem_in, num_in[DS-1-k]};
      ge       = (trial >= {1'b0, den_in});
      rem_d[k] = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
      quo_d[k] = {quo_in[ocv_pkg::QUO_W-2:0], ge};
      num_d[k] = num_in;
      den_d[k] = den_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DS; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < DS; k++) vld_q[k] <= vld_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DS; k++) begin
        rem_q[k]  <= rem_d[k];
        num_q[k]  <= num_d[k];
        den_q[k]  <= den_d[k];
        quo_q[k]  <= quo_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign vld_o  = vld_q[DS-1];
  assign quo_o  = quo_q[DS-1];
  assign side_o = side_q[DS-1];

endmodule

`default_nettype wire

### design/ocv_soc_interpolator.sv
// Stages in order: search, fetch, multiply, divider and output register.
// One word per cycle unless the output stalls: search, multiply and divider are staged.
// The whole pipe advances when the output register is empty or being taken.
// Reset (rst_ni, asynchronous, active low) clears all valid bits; data holds.
// Depends on ocv_pkg, ocv_search and ocv_div.
`default_nettype none

module ocv_soc_interpolator #(
  parameter int TABLE_POINTS = 101
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [15:0]                   cell_voltage_mv_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [13:0]                        charge_hundredths_o
);

  // Points in use: clamped to the table size and to a minimum of two.
  localparam int NU = (TABLE_POINTS > ocv_pkg::ROM_POINTS) ? ocv_pkg::ROM_POINTS :
                      (TABLE_POINTS < 2) ? 2 : TABLE_POINTS;
  localparam int LW = $clog2(NU + 1);

  // A single enable stalls every stage together, so nothing is lost or repeated.
  logic en;
  logic out_vld_q;
  logic [ocv_pkg::OUT_W-1:0] out_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // Search stages: count of table points strictly below the voltage.
  logic                     s_vld;
  logic [ocv_pkg::MV_W-1:0] s_v;
  logic [LW-1:0]            s_cnt;

  ocv_search #(.NU(NU), .LW(LW)) u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .v_i    (cell_voltage_mv_i),
    .vld_o  (s_vld),
    .v_o    (s_v),
    .cnt_o  (s_cnt)
  );

  // Fetch stage. A count of zero means at or below the first point, a count
  // of NU means above the last point; both take a flat percent. Otherwise the
  // segment runs from point cnt-1 to point cnt.
  logic                        below;
  logic                        above;
  ocv_pkg::rom_idx_t           lidx;
  ocv_pkg::rom_idx_t           ridx;
  logic [ocv_pkg::MV_W-1:0]    lmv;
  logic [ocv_pkg::MV_W-1:0]    rmv;
  logic [ocv_pkg::PCT_W-1:0]   lpct;
  logic [ocv_pkg::PCT_W-1:0]   rpct;

  assign below = (s_cnt == '0);
  assign above = (s_cnt == LW'(NU));

  always_comb begin
    if (below) begin
      lidx = '0;
    end else if (above) begin
      lidx = ocv_pkg::rom_idx_t'(NU - 1);
    end else begin
      lidx = ocv_pkg::rom_idx_t'(s_cnt - LW'(1));
    end
    ridx = (below || above) ? '0 : ocv_pkg::rom_idx_t'(s_cnt);
  end

  assign lmv  = ocv_pkg::ROM_MV[lidx];
  assign rmv  = ocv_pkg::ROM_MV[ridx];
  assign lpct = ocv_pkg::ROM_PCT[lidx];
  assign rpct = ocv_pkg::ROM_PCT[ridx];

  logic                         f_vld_q;
  logic [ocv_pkg::BASE_W-1:0]   f_base_q;
  logic [ocv_pkg::MV_W-1:0]     f_off_q;
  logic [ocv_pkg::MV_W-1:0]     f_dv_q;
  logic [ocv_pkg::PCT_W-1:0]    f_dp_q;
  logic                         f_useq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= s_vld;
    end
  end

  // A zero-width segment falls back to the left percent.
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_base_q <= ocv_pkg::BASE_W'(ocv_pkg::BASE_W'(lpct) * ocv_pkg::BASE_W'(100));
      f_off_q  <= s_v - lmv;
      f_dv_q   <= rmv - lmv;
      f_dp_q   <= rpct - lpct;
      f_useq_q <= !below && !above && (rmv != lmv);
    end
  end

  // Multiply stage: numerator = offset * percent step * 100.
  logic                         m_vld_q;
  logic [ocv_pkg::NUM_W-1:0]    m_num_q;
  logic [ocv_pkg::MV_W-1:0]     m_dv_q;
  ocv_pkg::side_t               m_side_q;
  logic [ocv_pkg::BASE_W-1:0]   dp100;

  assign dp100 = ocv_pkg::BASE_W'(ocv_pkg::BASE_W'(f_dp_q) * ocv_pkg::BASE_W'(100));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_num_q        <= ocv_pkg::NUM_W'(f_off_q) * ocv_pkg::NUM_W'(dp100);
      m_dv_q         <= f_dv_q;
      m_side_q.base  <= f_base_q;
      m_side_q.use_q <= f_useq_q;
    end
  end

  // Divider: the offset never exceeds the segment width, so the quotient is
  // at most the percent step times 100 and fits the divider's width.
  logic                         d_vld;
  logic [ocv_pkg::QUO_W-1:0]    d_quo;
  ocv_pkg::side_t               d_side;

  ocv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (m_vld_q),
    .num_i  (m_num_q),
    .den_i  (m_dv_q),
    .side_i (m_side_q),
    .vld_o  (d_vld),
    .quo_o  (d_quo),
    .side_o (d_side)
  );

  // Output register: base plus the interpolated part, kept to 14 bits.
  logic [ocv_pkg::BASE_W-1:0] sum;

  assign sum = d_side.base + (d_side.use_q ? d_quo : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= sum[ocv_pkg::OUT_W-1:0];
    end
  end

  assign out_valid_o         = out_vld_q;
  assign charge_hundredths_o = out_q;

endmodule

`default_nettype wire

### design/ocv_chk.sv
// Port-level checker for ocv_soc_interpolator and its bind statement.
// No package dependencies.
`default_nettype none

module ocv_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [15:0] cell_voltage_mv_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [13:0] charge_hundredths_o
);

  // The input side stalls exactly when a finished word waits untaken.
  a_ready_rel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  // A charge never exceeds one hundred percent.
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (charge_hundredths_o <= 14'd10000))
    else $error("charge out of range");

  // A stalled result word holds.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(charge_hundredths_o)))
    else $error("stalled result word changed");

  // While the output stalls, an offered input word is not taken.
  a_no_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken during output stall");

  // An offered input word that is not taken stays offered and unchanged.
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(cell_voltage_mv_i)))
    else $error("waiting input word changed");

endmodule

bind ocv_soc_interpolator ocv_chk u_ocv_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .cell_voltage_mv_i   (cell_voltage_mv_i),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .charge_hundredths_o (charge_hundredths_o)
);

`default_nettype wire
